// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the directory entry scanner checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== sv/fdes_pkg.sv =====
// ----------------------------------------------------------------------------
// fdes_pkg
// Types and constants shared by the FAT32 directory entry scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdes_pkg;

  localparam int ENTRY_COUNT_BITS = 16;
  localparam int ENTRY_NUMBER_W   = 16;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 64;

  localparam logic [7:0] MARK_DELETED   = 8'hE5;
  localparam logic [7:0] MARK_END       = 8'h00;
  localparam logic [7:0] ATTR_SKIP_MASK = 8'b0000_1110;
  localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
  localparam logic [7:0] DOT_CHAR       = 8'h2E;

  typedef enum logic [1:0] {
    MODE_LIST  = 2'd0,
    MODE_NAME  = 2'd1,
    MODE_INDEX = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_LIST  = 2'd0,
    KIND_MATCH = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEARCH_MODE  = 3'd0,
    REG_TARGET_INDEX = 3'd1,
    REG_TARGET_BASE  = 3'd2,
    REG_TARGET_EXT   = 3'd3,
    REG_ROOT_CLUSTER = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  search_mode;
    logic [15:0] target_index;
    logic [63:0] target_base_name;
    logic [23:0] target_ext;
    logic [31:0] root_cluster;
  } cfg_t;

  typedef struct packed {
    logic        new_search;
    logic        dir_end;
    logic [63:0] name_bytes;
    logic [23:0] ext_bytes;
    logic [7:0]  attributes;
    logic [15:0] cluster_high;
    logic [15:0] cluster_low;
    logic [31:0] entry_size;
  } item_t;

  typedef struct packed {
    kind_e                     kind;
    logic [ENTRY_NUMBER_W-1:0] entry_number;
    logic [31:0]               first_cluster;
    logic [31:0]               file_size;
    logic                      is_directory;
    logic [31:0]               total_size;
  } result_t;

endpackage

// ===== sv/fdes_eval.sv =====
// ----------------------------------------------------------------------------
// fdes_eval
// Classifies one directory entry against the scan state and the search
// settings, and gives the next scan state and the result, if any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdes_eval #(
  parameter int EntryCountBits = fdes_pkg::ENTRY_COUNT_BITS
) (
  input  fdes_pkg::item_t             item_i,
  input  fdes_pkg::cfg_t              cfg_i,
  input  logic [EntryCountBits-1:0]   count_i,
  input  logic [31:0]                 total_i,
  input  logic                        finished_i,
  output logic [EntryCountBits-1:0]   count_o,
  output logic [31:0]                 total_o,
  output logic                        finished_o,
  output logic                        emit_o,
  output fdes_pkg::result_t           result_o
);

  logic [EntryCountBits-1:0] count_base;
  logic [EntryCountBits-1:0] count_inc;
  logic [31:0]               total_base;
  logic [31:0]               total_inc;
  logic                      finished_base;
  logic [7:0]                b0;
  logic [7:0]                b1;
  logic                      skip;
  logic                      name_hit;
  logic                      index_hit;

  assign count_base    = item_i.new_search ? '0 : count_i;
  assign total_base    = item_i.new_search ? '0 : total_i;
  assign finished_base = item_i.new_search ? 1'b0 : finished_i;
  assign count_inc     = count_base + EntryCountBits'(1);
  assign total_inc     = total_base + item_i.entry_size;
  assign b0            = item_i.name_bytes[7:0];
  assign b1            = item_i.name_bytes[15:8];

  assign skip = (b0 == fdes_pkg::MARK_DELETED)
             || ((item_i.attributes & fdes_pkg::ATTR_SKIP_MASK) != 8'h00)
             || ((b0 == fdes_pkg::DOT_CHAR) && (b1 != fdes_pkg::DOT_CHAR));

  assign name_hit  = (item_i.name_bytes == cfg_i.target_base_name)
                  && (item_i.ext_bytes == cfg_i.target_ext);
  assign index_hit = (cfg_i.target_index != 16'd0)
                  && (fdes_pkg::ENTRY_NUMBER_W'(count_inc) == cfg_i.target_index);

  always_comb begin
    count_o    = count_base;
    total_o    = total_base;
    finished_o = finished_base;
    emit_o     = 1'b0;

    result_o.kind          = fdes_pkg::KIND_LIST;
    result_o.entry_number  = fdes_pkg::ENTRY_NUMBER_W'(count_inc);
    result_o.first_cluster = {item_i.cluster_high, item_i.cluster_low};
    result_o.file_size     = item_i.entry_size;
    result_o.is_directory  = (item_i.attributes & fdes_pkg::ATTR_DIRECTORY) != 8'h00;
    result_o.total_size    = total_inc;

    if (finished_base) begin
      emit_o = 1'b0;
    end else if (item_i.dir_end || (b0 == fdes_pkg::MARK_END)) begin
      finished_o             = 1'b1;
      emit_o                 = 1'b1;
      result_o.kind          = fdes_pkg::KIND_END;
      result_o.entry_number  = fdes_pkg::ENTRY_NUMBER_W'(count_base);
      result_o.first_cluster = (cfg_i.search_mode == fdes_pkg::MODE_NAME) ? 32'd0
                                                                          : cfg_i.root_cluster;
      result_o.file_size     = 32'd0;
      result_o.is_directory  = 1'b0;
      result_o.total_size    = total_base;
    end else if (!skip) begin
      count_o = count_inc;
      total_o = total_inc;
      case (cfg_i.search_mode)
        fdes_pkg::MODE_NAME: begin
          if (name_hit) begin
            finished_o    = 1'b1;
            emit_o        = 1'b1;
            result_o.kind = fdes_pkg::KIND_MATCH;
          end
        end
        fdes_pkg::MODE_INDEX: begin
          if (index_hit) begin
            finished_o    = 1'b1;
            emit_o        = 1'b1;
            result_o.kind = fdes_pkg::KIND_MATCH;
          end
        end
        default: begin
          emit_o = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== sv/fat_directory_entry_scanner.sv =====
// An entry is taken into the input register; its result is held in the result register.
// One entry per cycle unless the result stalls; counter and size total update on advance.
// A stalled result holds the result register while one more entry waits in the input register.
// Reset is asynchronous and active low: scan state clears, search mode 0, target index 1,
// target name and extension 0, root cluster 2, both pipeline stages empty.
// ----------------------------------------------------------------------------
// fat_directory_entry_scanner
// Scans FAT32 short directory entries, counts visible ones and lists them or
// finds one by 8+3 name or by entry number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_directory_entry_scanner #(
  parameter int EntryCountBits = fdes_pkg::ENTRY_COUNT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fdes_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [fdes_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                new_search_i,
  input  logic                                dir_end_i,
  input  logic [63:0]                         name_bytes_i,
  input  logic [23:0]                         ext_bytes_i,
  input  logic [7:0]                          attributes_i,
  input  logic [15:0]                         cluster_high_i,
  input  logic [15:0]                         cluster_low_i,
  input  logic [31:0]                         entry_size_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          result_kind_o,
  output logic [fdes_pkg::ENTRY_NUMBER_W-1:0] entry_number_o,
  output logic [31:0]                         first_cluster_o,
  output logic [31:0]                         file_size_o,
  output logic                                is_directory_o,
  output logic [31:0]                         total_size_o
);

  fdes_pkg::cfg_t            cfg_q;
  fdes_pkg::item_t           item_q;
  logic                      item_valid_q;
  logic [EntryCountBits-1:0] count_q;
  logic [EntryCountBits-1:0] count_d;
  logic [31:0]               total_q;
  logic [31:0]               total_d;
  logic                      finished_q;
  logic                      finished_d;
  logic                      emit;
  fdes_pkg::result_t         result_d;
  fdes_pkg::result_t         result_q;
  logic                      out_valid_q;
  logic                      advance;
  logic                      in_take;

  assign cfg_ready_o = 1'b1;

  // The input register moves on whenever the result register is free or drains.
  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.search_mode      <= fdes_pkg::MODE_LIST;
      cfg_q.target_index     <= 16'd1;
      cfg_q.target_base_name <= 64'd0;
      cfg_q.target_ext       <= 24'd0;
      cfg_q.root_cluster     <= 32'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fdes_pkg::REG_SEARCH_MODE:  cfg_q.search_mode      <= cfg_data_i[1:0];
        fdes_pkg::REG_TARGET_INDEX: cfg_q.target_index     <= cfg_data_i[15:0];
        fdes_pkg::REG_TARGET_BASE:  cfg_q.target_base_name <= cfg_data_i;
        fdes_pkg::REG_TARGET_EXT:   cfg_q.target_ext       <= cfg_data_i[23:0];
        fdes_pkg::REG_ROOT_CLUSTER: cfg_q.root_cluster     <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.new_search   <= new_search_i;
      item_q.dir_end      <= dir_end_i;
      item_q.name_bytes   <= name_bytes_i;
      item_q.ext_bytes    <= ext_bytes_i;
      item_q.attributes   <= attributes_i;
      item_q.cluster_high <= cluster_high_i;
      item_q.cluster_low  <= cluster_low_i;
      item_q.entry_size   <= entry_size_i;
    end
  end

  fdes_eval #(
    .EntryCountBits(EntryCountBits)
  ) u_eval (
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .count_i    (count_q),
    .total_i    (total_q),
    .finished_i (finished_q),
    .count_o    (count_d),
    .total_o    (total_d),
    .finished_o (finished_d),
    .emit_o     (emit),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      total_q    <= 32'd0;
      finished_q <= 1'b0;
    end else if (advance) begin
      count_q    <= count_d;
      total_q    <= total_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = result_q.kind;
  assign entry_number_o  = result_q.entry_number;
  assign first_cluster_o = result_q.first_cluster;
  assign file_size_o     = result_q.file_size;
  assign is_directory_o  = result_q.is_directory;
  assign total_size_o    = result_q.total_size;

endmodule

// ===== sv/fdes_checker.sv =====
// ----------------------------------------------------------------------------
// fdes_checker
// Port-level checks for the directory entry scanner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic [31:0] file_size_o,
  input logic        is_directory_o,
  input logic [31:0] total_size_o
);

  // A stalled result stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(result_kind_o) && $stable(total_size_o))

  // The input side only backs up when a result is waiting on a stalled receiver.
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A scan end carries no entry size and no directory flag.
  `ASSERT_IMPLIES(a_end_fields, clk_i, rst_ni,
    out_valid_o && (result_kind_o == fdes_pkg::KIND_END),
    (file_size_o == 32'd0) && !is_directory_o)

  // Register writes are never refused.
  `ASSERT_IMPLIES(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind fat_directory_entry_scanner fdes_checker u_fdes_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_kind_o  (result_kind_o),
  .file_size_o    (file_size_o),
  .is_directory_o (is_directory_o),
  .total_size_o   (total_size_o)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FAT32 directory entry scanner. A short scripted
// sequence covers every search mode, the skip rules and the field extremes.
// Random scans with random register settings follow. Every result is checked
// field by field against a local model of the scan or a scripted result.
// Input and output traffic is throttled at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [63:0] NAME_FILE    = 64'h2020_2020_454C_4946;
  localparam logic [63:0] NAME_MAIN    = 64'h2020_2020_4E49_414D;
  localparam logic [63:0] NAME_DELETED = 64'h2020_2020_454C_49E5;
  localparam logic [63:0] NAME_DOT     = 64'h2020_2020_2020_202E;
  localparam logic [63:0] NAME_DOTDOT  = 64'h2020_2020_2020_2E2E;
  localparam logic [63:0] NAME_ENDMARK = 64'h2020_2020_2020_2000;
  localparam logic [23:0] EXT_TXT      = 24'h545854;
  localparam logic [23:0] EXT_BIN      = 24'h4E4942;

  typedef struct {
    bit                 is_cfg;
    fdes_pkg::cfg_reg_e reg_idx;
    logic [63:0]        reg_val;
    fdes_pkg::item_t    entry;
    bit                 typed;
    fdes_pkg::result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [fdes_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fdes_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  fdes_pkg::item_t entry_bus = '0;
  logic out_stall = 1'b0;

  logic cfg_ready;
  logic in_stall;
  logic out_valid;
  logic [1:0] res_kind;
  logic [fdes_pkg::ENTRY_NUMBER_W-1:0] res_number;
  logic [31:0] res_cluster;
  logic [31:0] res_size;
  logic res_dir;
  logic [31:0] res_total;

  fdes_pkg::result_t due_results[$];
  fdes_pkg::cfg_t shadow_cfg;
  logic [fdes_pkg::ENTRY_COUNT_BITS-1:0] visible_count;
  logic [31:0] byte_total;
  bit scan_done;
  int live_items = 0;
  int errors = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit last_emitted;
  int stall_style = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  fat_directory_entry_scanner uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .new_search_i   (entry_bus.new_search),
    .dir_end_i      (entry_bus.dir_end),
    .name_bytes_i   (entry_bus.name_bytes),
    .ext_bytes_i    (entry_bus.ext_bytes),
    .attributes_i   (entry_bus.attributes),
    .cluster_high_i (entry_bus.cluster_high),
    .cluster_low_i  (entry_bus.cluster_low),
    .entry_size_i   (entry_bus.entry_size),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (res_kind),
    .entry_number_o (res_number),
    .first_cluster_o(res_cluster),
    .file_size_o    (res_size),
    .is_directory_o (res_dir),
    .total_size_o   (res_total)
  );

  function automatic fdes_pkg::item_t mk_entry(bit ns, bit de, logic [63:0] name,
                                               logic [23:0] ext, logic [7:0] attr,
                                               logic [31:0] clus, logic [31:0] size);
    fdes_pkg::item_t e;
    e.new_search = ns;
    e.dir_end = de;
    e.name_bytes = name;
    e.ext_bytes = ext;
    e.attributes = attr;
    {e.cluster_high, e.cluster_low} = clus;
    e.entry_size = size;
    return e;
  endfunction

  function automatic fdes_pkg::result_t mk_result(fdes_pkg::kind_e k,
                                                  logic [fdes_pkg::ENTRY_NUMBER_W-1:0] num,
                                                  logic [31:0] clus, logic [31:0] size,
                                                  logic dir, logic [31:0] total);
    fdes_pkg::result_t r;
    r.kind = k;
    r.entry_number = num;
    r.first_cluster = clus;
    r.file_size = size;
    r.is_directory = dir;
    r.total_size = total;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(fdes_pkg::cfg_reg_e idx, logic [63:0] v);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = v;
    row.entry = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t entry_row(fdes_pkg::item_t e);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = fdes_pkg::REG_SEARCH_MODE;
    row.reg_val = '0;
    row.entry = e;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(fdes_pkg::item_t e, fdes_pkg::result_t want);
    stim_row_t row;
    row = entry_row(e);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, msg);
    end
  endfunction

  // Steps the scan state for one accepted entry and queues the result it causes.
  function automatic bit predict_scan(fdes_pkg::item_t e);
    logic [7:0] lead;
    logic [7:0] second;
    logic [31:0] clus;
    logic dir;
    bit hit;
    lead = e.name_bytes[7:0];
    second = e.name_bytes[15:8];
    clus = {e.cluster_high, e.cluster_low};
    dir = (e.attributes & fdes_pkg::ATTR_DIRECTORY) != 0;
    hit = 1'b0;
    live_items++;
    if (e.new_search) begin
      visible_count = '0;
      byte_total = '0;
      scan_done = 1'b0;
    end
    if (scan_done) begin
      return 1'b0;
    end
    if (e.dir_end || lead == fdes_pkg::MARK_END) begin
      scan_done = 1'b1;
      due_results.push_back(mk_result(fdes_pkg::KIND_END, visible_count,
                                      (shadow_cfg.search_mode == fdes_pkg::MODE_NAME) ? 32'd0 :
                                      shadow_cfg.root_cluster, '0, 1'b0, byte_total));
      return 1'b1;
    end
    if (lead == fdes_pkg::MARK_DELETED || (e.attributes & fdes_pkg::ATTR_SKIP_MASK) != 0 ||
        (lead == fdes_pkg::DOT_CHAR && second != fdes_pkg::DOT_CHAR)) begin
      return 1'b0;
    end
    visible_count++;
    byte_total += e.entry_size;
    case (shadow_cfg.search_mode)
      fdes_pkg::MODE_NAME: begin
        hit = e.name_bytes == shadow_cfg.target_base_name &&
              e.ext_bytes == shadow_cfg.target_ext;
      end
      fdes_pkg::MODE_INDEX: begin
        hit = shadow_cfg.target_index != 0 && visible_count == shadow_cfg.target_index;
      end
      default: begin
        due_results.push_back(mk_result(fdes_pkg::KIND_LIST, visible_count, clus,
                                        e.entry_size, dir, byte_total));
        return 1'b1;
      end
    endcase
    if (!hit) begin
      return 1'b0;
    end
    scan_done = 1'b1;
    due_results.push_back(mk_result(fdes_pkg::KIND_MATCH, visible_count, clus, e.entry_size,
                                    dir, byte_total));
    return 1'b1;
  endfunction

  function automatic fdes_pkg::item_t rand_entry(bit plain);
    fdes_pkg::item_t e;
    int pick;
    e.new_search = 1'b0;
    e.dir_end = 1'b0;
    e.name_bytes = {$urandom, $urandom};
    e.ext_bytes = 24'($urandom);
    e.attributes = 8'($urandom);
    {e.cluster_high, e.cluster_low} = $urandom;
    e.entry_size = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom;
    pick = plain ? 0 : $urandom_range(0, 99);
    if (pick < 60) begin
      if (e.name_bytes[7:0] == fdes_pkg::MARK_END ||
          e.name_bytes[7:0] == fdes_pkg::MARK_DELETED ||
          e.name_bytes[7:0] == fdes_pkg::DOT_CHAR) begin
        e.name_bytes[7:0] = 8'h5F;
      end
      e.attributes = e.attributes & ~fdes_pkg::ATTR_SKIP_MASK;
    end else if (pick < 66) begin
      e.name_bytes[7:0] = fdes_pkg::MARK_DELETED;
    end else if (pick < 74) begin
      e.attributes[$urandom_range(1, 3)] = 1'b1;
    end else if (pick < 80) begin
      e.attributes = 8'h0F;
    end else if (pick < 86) begin
      e.name_bytes[7:0] = fdes_pkg::DOT_CHAR;
      e.attributes = e.attributes & ~fdes_pkg::ATTR_SKIP_MASK;
    end else if (pick < 92) begin
      e.name_bytes[15:0] = {fdes_pkg::DOT_CHAR, fdes_pkg::DOT_CHAR};
      e.attributes = e.attributes & ~fdes_pkg::ATTR_SKIP_MASK;
    end
    return e;
  endfunction

  task automatic send_entry(fdes_pkg::item_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gaps_on && gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    entry_bus <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_emitted = predict_scan(e);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(fdes_pkg::cfg_reg_e idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fdes_pkg::REG_SEARCH_MODE:  shadow_cfg.search_mode = v[1:0];
      fdes_pkg::REG_TARGET_INDEX: shadow_cfg.target_index = v[15:0];
      fdes_pkg::REG_TARGET_BASE:  shadow_cfg.target_base_name = v;
      fdes_pkg::REG_TARGET_EXT:   shadow_cfg.target_ext = v[23:0];
      fdes_pkg::REG_ROOT_CLUSTER: shadow_cfg.root_cluster = v[31:0];
      default: ;
    endcase
  endtask

  task automatic load_config(fdes_pkg::cfg_t c);
    wait_quiet();
    write_reg(fdes_pkg::REG_SEARCH_MODE, 64'(c.search_mode));
    write_reg(fdes_pkg::REG_TARGET_INDEX, 64'(c.target_index));
    write_reg(fdes_pkg::REG_TARGET_BASE, c.target_base_name);
    write_reg(fdes_pkg::REG_TARGET_EXT, 64'(c.target_ext));
    write_reg(fdes_pkg::REG_ROOT_CLUSTER, 64'(c.root_cluster));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_left % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    fdes_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d number %0d cluster %h",
                             res_kind, res_number, res_cluster));
      end else begin
        want = due_results.pop_front();
        if (res_kind !== want.kind || res_number !== want.entry_number ||
            res_cluster !== want.first_cluster || res_size !== want.file_size ||
            res_dir !== want.is_directory || res_total !== want.total_size) begin
          flag_error($sformatf({"result mismatch (expected/actual): kind %0d/%0d ",
                                "number %0d/%0d cluster %h/%h size %h/%h dir %0d/%0d ",
                                "total %h/%h"},
                               want.kind, res_kind, want.entry_number, res_number,
                               want.first_cluster, res_cluster, want.file_size, res_size,
                               want.is_directory, res_dir, want.total_size, res_total));
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    stim_row_t script[$];
    fdes_pkg::cfg_t c;
    fdes_pkg::item_t e;
    int len;
    int pick;
    int goal;

    shadow_cfg.search_mode = fdes_pkg::MODE_LIST;
    shadow_cfg.target_index = 16'd1;
    shadow_cfg.target_base_name = '0;
    shadow_cfg.target_ext = '0;
    shadow_cfg.root_cluster = 32'd2;
    visible_count = '0;
    byte_total = '0;
    scan_done = 1'b0;

    script.push_back(checked_row(mk_entry(1, 0, NAME_FILE, EXT_TXT, 8'h20, 32'd3, 32'd100),
                                 mk_result(fdes_pkg::KIND_LIST, 1, 32'd3, 32'd100, 1'b0,
                                           32'd100)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_DELETED, EXT_TXT, 8'h20, 32'd4, 32'd5)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_FILE, EXT_TXT, 8'h02, 32'd4, 32'd5)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_FILE, EXT_TXT, 8'h04, 32'd4, 32'd5)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_FILE, EXT_TXT, 8'h08, 32'd4, 32'd5)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_FILE, EXT_TXT, 8'h0F, 32'd4, 32'd5)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_DOT, '0, 8'h10, 32'd7, 32'd0)));
    script.push_back(checked_row(mk_entry(0, 0, NAME_DOTDOT, '0, 8'h10, 32'd0, 32'd0),
                                 mk_result(fdes_pkg::KIND_LIST, 2, 32'd0, 32'd0, 1'b1,
                                           32'd100)));
    script.push_back(checked_row(mk_entry(0, 0, '1, '1, 8'hF1, '1, '1),
                                 mk_result(fdes_pkg::KIND_LIST, 3, 32'hFFFF_FFFF,
                                           32'hFFFF_FFFF, 1'b1, 32'd99)));
    script.push_back(checked_row(mk_entry(0, 1, '1, '1, '1, '1, '1),
                                 mk_result(fdes_pkg::KIND_END, 3, 32'd2, 32'd0, 1'b0,
                                           32'd99)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_FILE, EXT_TXT, 8'h20, 32'd5, 32'd6)));
    script.push_back(checked_row(mk_entry(1, 0, 64'hFFFF_FFFF_FFFF_FF00, '1, '1, '1, '1),
                                 mk_result(fdes_pkg::KIND_END, 0, 32'd2, 32'd0, 1'b0,
                                           32'd0)));
    script.push_back(cfg_row(fdes_pkg::REG_SEARCH_MODE, 64'(fdes_pkg::MODE_NAME)));
    script.push_back(cfg_row(fdes_pkg::REG_TARGET_BASE, NAME_MAIN));
    script.push_back(cfg_row(fdes_pkg::REG_TARGET_EXT, 64'(EXT_BIN)));
    script.push_back(entry_row(mk_entry(1, 0, NAME_FILE, EXT_TXT, 8'h20, 32'd3, 32'd100)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_MAIN, 24'h4D4942, 8'h20, 32'd8, 32'd7)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_MAIN, EXT_BIN, 8'h10, 32'h0001_2345,
                                        32'd4096)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_MAIN, EXT_BIN, 8'h20, 32'd9, 32'd1)));
    script.push_back(checked_row(mk_entry(1, 1, NAME_MAIN, EXT_BIN, 8'h20, 32'd9, 32'd1),
                                 mk_result(fdes_pkg::KIND_END, 0, 32'd0, 32'd0, 1'b0,
                                           32'd0)));
    script.push_back(cfg_row(fdes_pkg::REG_SEARCH_MODE, 64'(fdes_pkg::MODE_INDEX)));
    script.push_back(cfg_row(fdes_pkg::REG_TARGET_INDEX, 64'd2));
    script.push_back(cfg_row(fdes_pkg::REG_ROOT_CLUSTER, 64'hFFFF_FFFF));
    script.push_back(entry_row(mk_entry(1, 0, NAME_FILE, EXT_TXT, 8'h01, 32'd10, 32'd11)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_DELETED, EXT_TXT, 8'h20, 32'd4, 32'd5)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_MAIN, EXT_BIN, 8'h30, 32'd12, 32'd13)));
    script.push_back(entry_row(mk_entry(1, 0, NAME_FILE, EXT_TXT, 8'h20, 32'd14, 32'd15)));
    script.push_back(entry_row(mk_entry(0, 1, NAME_MAIN, EXT_BIN, 8'h20, 32'd1, 32'd1)));
    script.push_back(cfg_row(fdes_pkg::REG_TARGET_INDEX, 64'd0));
    script.push_back(entry_row(mk_entry(1, 0, NAME_FILE, EXT_TXT, 8'h20, 32'd16, 32'd17)));
    script.push_back(entry_row(mk_entry(0, 0, NAME_ENDMARK, EXT_TXT, 8'h20, 32'd1, 32'd1)));
    script.push_back(cfg_row(fdes_pkg::REG_SEARCH_MODE, 64'(MODE_UNDEF)));
    script.push_back(cfg_row(fdes_pkg::REG_ROOT_CLUSTER, 64'd0));
    script.push_back(entry_row(mk_entry(1, 0, NAME_MAIN, EXT_BIN, 8'h10, 32'd18, 32'd19)));
    script.push_back(entry_row(mk_entry(0, 1, NAME_MAIN, EXT_BIN, 8'h10, 32'd18, 32'd19)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_quiet();
        write_reg(script[i].reg_idx, script[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_entry(script[i].entry);
        if (script[i].typed) begin
          if (!last_emitted) begin
            flag_error($sformatf("scripted row %0d produced no result in the model", i));
          end else begin
            void'(due_results.pop_back());
            due_results.push_back(script[i].want);
          end
        end
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c.search_mode = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      c.target_index = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                       (pick == 2) ? 16'd1 : 16'($urandom_range(2, 30));
      c.target_base_name = ($urandom_range(0, 4) == 0) ? '1 : {$urandom, $urandom};
      if (c.target_base_name[7:0] == fdes_pkg::MARK_END ||
          c.target_base_name[7:0] == fdes_pkg::MARK_DELETED ||
          c.target_base_name[7:0] == fdes_pkg::DOT_CHAR) begin
        c.target_base_name[7:0] = 8'h4D;
      end
      pick = $urandom_range(0, 5);
      c.target_ext = (pick == 0) ? '0 : (pick == 1) ? '1 : 24'($urandom);
      pick = $urandom_range(0, 5);
      c.root_cluster = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
      load_config(c);
      gaps_on = ($urandom_range(0, 3) != 0);
      goal = live_items + ITEMS_PER_PHASE;
      while (live_items < goal) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 25);
        for (int k = 0; k <= len; k++) begin
          e = rand_entry(1'b0);
          if (shadow_cfg.search_mode == fdes_pkg::MODE_NAME && $urandom_range(0, 5) == 0) begin
            e.name_bytes = shadow_cfg.target_base_name;
            e.ext_bytes = shadow_cfg.target_ext;
            e.attributes = e.attributes & ~fdes_pkg::ATTR_SKIP_MASK;
          end
          e.new_search = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0);
          e.dir_end = ($urandom_range(0, 99) == 0);
          send_entry(e);
        end
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          e = rand_entry(1'b0);
          e.dir_end = (pick < 5);
          if (pick >= 5) begin
            e.name_bytes[7:0] = fdes_pkg::MARK_END;
          end
          send_entry(e);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_entry(rand_entry(1'b0));
        end
      end
    end

    wait_quiet();
    if (due_results.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", due_results.size()));
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fdes_pkg.sv
sv/fdes_eval.sv
sv/fat_directory_entry_scanner.sv
sv/fdes_checker.sv
verif/tb.sv
